### hdl/quaternion_nlerp_defines.svh
// Assertion macros for the quaternion nlerp block.
// Used by the top level only; expects clock and reset in scope.
`ifndef QUATERNION_NLERP_DEFINES_SVH
`define QUATERNION_NLERP_DEFINES_SVH

// same-cycle implication
`define QNL_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("quaternion_nlerp assertion failed");

// next-cycle implication
`define QNL_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("quaternion_nlerp assertion failed");

`endif

### hdl/qnl_pkg.sv
// Shared types, widths and the reciprocal square root seed table.
// No dependencies.
`timescale 1ns / 1ps
package qnl_pkg;
   localparam int COMP_W = 16;
   localparam int O_W    = 17;
   localparam int Y_W    = 32;
   localparam int M_W    = 34;
   localparam int H_W    = 5;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [COMP_W-1:0]        weight_type;
   typedef logic signed [O_W-1:0]    blend_type;
   typedef logic [Y_W-1:0]           rsq_type;
   typedef logic [M_W-1:0]           mant_type;
   typedef logic [H_W-1:0]           shift_type;

   function automatic rsq_type seed_lookup(input logic [2:0] idx);
      rsq_type s;
      case (idx)
         3'd0:    s = 32'd2147483648;
         3'd1:    s = 32'd2147483648;
         3'd2:    s = 32'd1920767357;
         3'd3:    s = 32'd1623345166;
         3'd4:    s = 32'd1431655765;
         3'd5:    s = 32'd1294980958;
         3'd6:    s = 32'd1191209180;
         3'd7:    s = 32'd1108956261;
         default: s = 32'd2147483648;
      endcase
      return s;
   endfunction
endpackage

### hdl/qnl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on qnl_pkg.
`timescale 1ns / 1ps
interface qnl_req_if;
   logic                 valid;
   logic                 ready;
   qnl_pkg::comp_type    a_x, a_y, a_z, a_w;
   qnl_pkg::comp_type    b_x, b_y, b_z, b_w;
   qnl_pkg::weight_type  weight;
   modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, weight,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, weight,
                   output ready);
endinterface

interface qnl_rsp_if;
   logic                 valid;
   logic                 ready;
   qnl_pkg::comp_type    r_x, r_y, r_z, r_w;
   logic                 degenerate;
   modport source (output valid, r_x, r_y, r_z, r_w, degenerate, input ready);
   modport sink   (input valid, r_x, r_y, r_z, r_w, degenerate, output ready);
endinterface

### hdl/quaternion_nlerp.sv
// channel  dir  fields                                   handshake
// req      in   a_x..a_w, b_x..b_w, weight               valid/ready
// rsp      out  r_x..r_w, degenerate                     valid/ready
// One item per cycle while rsp is not stalled; the Newton pipeline in
// qnl_rsqrt has three multiply stages per step.
// Synchronous reset clears the valid pipeline only; no clearing pass.
// A stalled response freezes the whole pipeline; req.ready follows it.
// Depends on qnl_pkg, qnl_if, qnl_lane, qnl_rsqrt, qnl_scale.
`timescale 1ns / 1ps
module quaternion_nlerp #(
   parameter int COMP_FRAC_BITS   = 14,
   parameter int WEIGHT_FRAC_BITS = 15,
   parameter int RSQRT_STEPS      = 3
) (
   input logic       clock,
   input logic       reset,
   qnl_req_if.sink   req,
   qnl_rsp_if.source rsp
);
   import qnl_pkg::*;
   `include "quaternion_nlerp_defines.svh"

   localparam int WW  = WEIGHT_FRAC_BITS + 1;
   localparam int TW  = ((WW > COMP_W) ? WW : COMP_W) + 1;
   localparam int LAT = 3 * RSQRT_STEPS;
   localparam int NST = 8 + LAT;
   localparam logic [TW-1:0] ONE = TW'(1) << WEIGHT_FRAC_BITS;

   typedef struct packed {
      blend_type [3:0] o;
      shift_type       h;
      logic            zero;
   } side_type;

   logic            adv;
   logic [NST-1:0]  valid_ff, valid_in;
   logic [TW-1:0]   w_ext, t_full;
   logic [WW-1:0]   t, inv;
   comp_type        a [4];
   comp_type        b [4];
   logic signed [31:0] ab [4];
   blend_type       o4 [4];
   logic [31:0]     sq4 [4];
   logic            dot_neg_ff, dot_neg_in;
   logic signed [33:0] dot;
   logic [32:0]     sq_ff, sq_in;
   blend_type       o5_ff [4];
   shift_type       h;
   mant_type        m_ff, m_in;
   rsq_type         seed_ff, y;
   side_type        side_ff [LAT+1];
   logic            zero_a_ff, zero_b_ff;
   comp_type        r [4];

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;
   assign a[0] = req.a_x; assign a[1] = req.a_y; assign a[2] = req.a_z; assign a[3] = req.a_w;
   assign b[0] = req.b_x; assign b[1] = req.b_y; assign b[2] = req.b_z; assign b[3] = req.b_w;

   always_comb begin
      w_ext  = TW'(req.weight);
      t_full = (w_ext > ONE) ? ONE : w_ext;
      t      = t_full[WW-1:0];
      inv    = WW'(ONE - t_full);
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      qnl_lane #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_lane (
         .clock(clock), .adv(adv), .a(a[i]), .b(b[i]), .t(t), .inv(inv),
         .dot_neg(dot_neg_ff), .ab(ab[i]), .o(o4[i]), .sq(sq4[i]));
   end

   always_comb begin
      dot = 34'(ab[0]) + 34'(ab[1]) + 34'(ab[2]) + 34'(ab[3]);
      dot_neg_in = dot[33];
      sq_in = 33'(sq4[0]) + 33'(sq4[1]) + 33'(sq4[2]) + 33'(sq4[3]);
      h = '0;
      for (int k = 16; k >= 0; k--) begin
         if (sq_ff >= (33'd1 << (32 - 2 * k))) begin
            h = H_W'(k);
         end
      end
      m_in = M_W'(sq_ff) << (2 * h);
      valid_in = {valid_ff[NST-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_neg_ff <= dot_neg_in;
         sq_ff      <= sq_in;
         for (int i = 0; i < 4; i++) begin
            o5_ff[i]       <= o4[i];
            side_ff[0].o[i] <= o5_ff[i];
         end
         side_ff[0].h    <= h;
         side_ff[0].zero <= (sq_ff == '0);
         m_ff            <= m_in;
         seed_ff         <= seed_lookup(m_in[33:31]);
         for (int j = 1; j <= LAT; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         zero_a_ff <= side_ff[LAT].zero;
         zero_b_ff <= zero_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   qnl_rsqrt #(.RSQRT_STEPS(RSQRT_STEPS)) u_rsqrt (
      .clock(clock), .adv(adv), .m(m_ff), .seed(seed_ff), .y(y));

   for (genvar i = 0; i < 4; i++) begin : g_scale
      qnl_scale #(.COMP_FRAC_BITS(COMP_FRAC_BITS)) u_scale (
         .clock(clock), .adv(adv), .o(side_ff[LAT].o[i]), .y(y),
         .h(side_ff[LAT].h), .zero(side_ff[LAT].zero), .r(r[i]));
   end

   assign rsp.valid      = valid_ff[NST-1];
   assign rsp.r_x        = r[0];
   assign rsp.r_y        = r[1];
   assign rsp.r_z        = r[2];
   assign rsp.r_w        = r[3];
   assign rsp.degenerate = zero_b_ff;

   `QNL_ASSERT_IMP(a_degen_zero, rsp.valid && rsp.degenerate,
      rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0 && rsp.r_w == '0)
   `QNL_ASSERT_IMP(a_stall_holds_req, rsp.valid && !rsp.ready, !req.ready)
   `QNL_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, valid_ff[0])
endmodule

### hdl/qnl_lane.sv
// One component lane: products, blend with rounding, and square.
// Depends on qnl_pkg. Four stages, all advanced by adv.
`timescale 1ns / 1ps
module qnl_lane #(
   parameter int WEIGHT_FRAC_BITS = 15
) (
   input  logic                 clock,
   input  logic                 adv,
   input  qnl_pkg::comp_type    a,
   input  qnl_pkg::comp_type    b,
   input  logic [WEIGHT_FRAC_BITS:0] t,
   input  logic [WEIGHT_FRAC_BITS:0] inv,
   input  logic                 dot_neg,
   output logic signed [31:0]   ab,
   output qnl_pkg::blend_type   o,
   output logic [31:0]          sq
);
   import qnl_pkg::*;
   localparam int WW = WEIGHT_FRAC_BITS + 1;
   localparam int PW = COMP_W + WW + 1;
   localparam int SW = PW + 1;

   logic signed [31:0]   ab_ff, ab_in;
   logic signed [PW-1:0] ainv_ff, ainv_in, bt_ff, bt_in, ainv2_ff, bt2_ff;
   logic signed [SW-1:0] bsel, blend;
   logic [SW-1:0]        mag, mag_rnd;
   blend_type            o_ff, o_in, o4_ff;
   logic [31:0]          sq_ff, sq_in;
   logic signed [2*O_W-1:0] o_sq;

   always_comb begin
      ab_in   = a * b;
      ainv_in = a * $signed({1'b0, inv});
      bt_in   = b * $signed({1'b0, t});
      bsel    = dot_neg ? -SW'(bt2_ff) : SW'(bt2_ff);
      blend   = SW'(ainv2_ff) + bsel;
      mag     = blend[SW-1] ? SW'(-blend) : SW'(blend);
      mag_rnd = (mag + (SW'(1) << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
      o_in    = blend[SW-1] ? -O_W'(mag_rnd) : O_W'(mag_rnd);
      o_sq    = o_ff * o_ff;
      sq_in   = o_sq[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ab_ff    <= ab_in;
         ainv_ff  <= ainv_in;
         bt_ff    <= bt_in;
         ainv2_ff <= ainv_ff;
         bt2_ff   <= bt_ff;
         o_ff     <= o_in;
         o4_ff    <= o_ff;
         sq_ff    <= sq_in;
      end
   end

   assign ab = ab_ff;
   assign o  = o4_ff;
   assign sq = sq_ff;
endmodule

### hdl/qnl_rsqrt.sv
// Pipelined Newton reciprocal square root, three stages per step.
// Depends on qnl_pkg. Input m in [2^32, 2^34), y in unsigned Q1.31.
`timescale 1ns / 1ps
module qnl_rsqrt #(
   parameter int RSQRT_STEPS = 3
) (
   input  logic               clock,
   input  logic               adv,
   input  qnl_pkg::mant_type  m,
   input  qnl_pkg::rsq_type   seed,
   output qnl_pkg::rsq_type   y
);
   import qnl_pkg::*;
   localparam logic [32:0] THREE = 33'h0C000_0000;

   rsq_type  y_st [RSQRT_STEPS+1];
   mant_type m_st [RSQRT_STEPS+1];

   assign y_st[0] = seed;
   assign m_st[0] = m;

   for (genvar i = 0; i < RSQRT_STEPS; i++) begin : g_step
      rsq_type     ya_ff, yb_ff, yc_ff, yc_in;
      mant_type    ma_ff, mb_ff, mc_ff;
      logic [32:0] y2_ff, y2_in, xy2_ff, xy2_in;
      logic [63:0] ysq, yd;
      logic [62:0] mxy;
      logic [31:0] d;

      always_comb begin
         ysq    = 64'(y_st[i]) * 64'(y_st[i]);
         y2_in  = ysq[62:30];
         mxy    = 63'(ma_ff[M_W-1:4]) * 63'(y2_ff);
         xy2_in = mxy[62:30];
         d      = (xy2_ff > THREE) ? 32'd0 : 32'(THREE - xy2_ff);
         yd     = 64'(yb_ff) * 64'(d);
         yc_in  = yd[62:31];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ya_ff  <= y_st[i];
            ma_ff  <= m_st[i];
            y2_ff  <= y2_in;
            yb_ff  <= ya_ff;
            mb_ff  <= ma_ff;
            xy2_ff <= xy2_in;
            yc_ff  <= yc_in;
            mc_ff  <= mb_ff;
         end
      end

      assign y_st[i+1] = yc_ff;
      assign m_st[i+1] = mc_ff;
   end

   assign y = y_st[RSQRT_STEPS];
endmodule

### hdl/qnl_scale.sv
// Output lane: scales a blended component by the reciprocal root,
// rounds and saturates. Depends on qnl_pkg. Two stages.
`timescale 1ns / 1ps
module qnl_scale #(
   parameter int COMP_FRAC_BITS = 14
) (
   input  logic                clock,
   input  logic                adv,
   input  qnl_pkg::blend_type  o,
   input  qnl_pkg::rsq_type    y,
   input  qnl_pkg::shift_type  h,
   input  logic                zero,
   output qnl_pkg::comp_type   r
);
   import qnl_pkg::*;
   localparam int PW = O_W + Y_W + 1;
   localparam logic [5:0] SBASE = 6'(47 - COMP_FRAC_BITS);

   logic signed [PW-1:0] p_ff, p_in;
   shift_type            h_ff;
   logic                 zero_ff;
   logic [PW-1:0]        mag, rnd;
   logic [5:0]           s;
   comp_type             r_ff, r_in;

   always_comb begin
      p_in = o * $signed({1'b0, y});
      s    = SBASE - 6'(h_ff);
      mag  = p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff);
      rnd  = (mag + (PW'(1) << (s - 6'd1))) >> s;
      if (zero_ff) begin
         r_in = '0;
      end else if (p_ff[PW-1]) begin
         r_in = (rnd > PW'(32768)) ? comp_type'(-32768) : -comp_type'(rnd[COMP_W-1:0]);
      end else begin
         r_in = (rnd > PW'(32767)) ? comp_type'(32767) : comp_type'(rnd[COMP_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         h_ff    <= h;
         zero_ff <= zero;
         r_ff    <= r_in;
      end
   end

   assign r = r_ff;
endmodule

### tb/tb_quaternion_nlerp.sv
// Self-checking testbench for quaternion_nlerp: random valid/ready gaps on both channels,
// a built-in fixed-point nlerp predictor and an in-order result queue.
// Depends on qnl_pkg, qnl_if and the quaternion_nlerp RTL.
`timescale 1ns / 1ps
module tb_quaternion_nlerp;
   import qnl_pkg::*;

   typedef struct {
      comp_type   a [4];
      comp_type   b [4];
      weight_type weight;
   } blend_req_type;

   typedef struct {
      comp_type r [4];
      logic     degenerate;
   } unit_quat_type;

   localparam int N_RANDOM = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches = 0;
   bit   stim_done = 1'b0;

   blend_req_type pending_q [$];
   unit_quat_type expected_q [$];

   qnl_req_if req ();
   qnl_rsp_if rsp ();

   quaternion_nlerp uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #5 clock = ~clock;

   function automatic longint div_round(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic unit_quat_type nlerp_predict(blend_req_type it);
      unit_quat_type res;
      longint a [4], b [4], o [4];
      longint t, inv, dot, rv;
      logic [63:0] sq, m, y, y2, xy2, d, seed;
      int h;
      t = it.weight;
      dot = 0;
      sq = 0;
      h = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = it.a[i];
         b[i] = it.b[i];
         dot += a[i] * b[i];
      end
      if (t > 32768) t = 32768;
      inv = 32768 - t;
      if (dot < 0) t = -t;
      for (int i = 0; i < 4; i++) begin
         o[i] = div_round(a[i] * inv + b[i] * t, 15);
         sq += o[i] * o[i];
      end
      if (sq == 0) begin
         foreach (res.r[i]) res.r[i] = '0;
         res.degenerate = 1'b1;
         return res;
      end
      m = sq;
      while (m < (64'd1 << 32)) begin
         m = m << 2;
         h++;
      end
      case (m[33:31])
         3'd0, 3'd1: seed = 64'd2147483648;
         3'd2:       seed = 64'd1920767357;
         3'd3:       seed = 64'd1623345166;
         3'd4:       seed = 64'd1431655765;
         3'd5:       seed = 64'd1294980958;
         3'd6:       seed = 64'd1191209180;
         default:    seed = 64'd1108956261;
      endcase
      y = seed;
      for (int k = 0; k < 3; k++) begin
         y2 = (y * y) >> 30;
         xy2 = ((m >> 4) * y2) >> 30;
         d = (xy2 > (64'd3 << 30)) ? 64'd0 : (64'd3 << 30) - xy2;
         y = (y * d) >> 31;
      end
      for (int i = 0; i < 4; i++) begin
         rv = div_round(o[i] * longint'(y), 33 - h);
         if (rv > 32767) rv = 32767;
         if (rv < -32768) rv = -32768;
         res.r[i] = comp_type'(rv);
      end
      res.degenerate = 1'b0;
      return res;
   endfunction

   task automatic report(string what, int got, int want);
      mismatches++;
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic comp_type rand_comp(int mode);
      case (mode)
         0: return comp_type'($urandom);
         1: return comp_type'($urandom_range(0, 32767) - 16384);
         default: return comp_type'($urandom_range(0, 64) - 32);
      endcase
   endfunction

   task automatic push_item(comp_type a [4], comp_type b [4], weight_type w);
      blend_req_type it;
      it.a = a;
      it.b = b;
      it.weight = w;
      pending_q.push_back(it);
   endtask

   // driver
   int req_gap = 0;
   always @(posedge clock) begin
      blend_req_type it;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            it.a = '{req.a_x, req.a_y, req.a_z, req.a_w};
            it.b = '{req.b_x, req.b_y, req.b_z, req.b_w};
            it.weight = req.weight;
            expected_q.push_back(nlerp_predict(it));
            void'(pending_q.pop_front());
            req_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         end
         if ((!req.valid || req.ready) && req_gap > 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (!req.valid || req.ready) begin
            if (pending_q.size() > (req.valid && req.ready ? 0 : 0) && pending_q.size() > 0)
            begin
               it = pending_q[0];
               req.valid  <= 1'b1;
               req.a_x    <= it.a[0];
               req.a_y    <= it.a[1];
               req.a_z    <= it.a[2];
               req.a_w    <= it.a[3];
               req.b_x    <= it.b[0];
               req.b_y    <= it.b[1];
               req.b_z    <= it.b[2];
               req.b_w    <= it.b[3];
               req.weight <= it.weight;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      unit_quat_type want;
      comp_type      got [4];
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.r_x, rsp.r_y, rsp.r_z, rsp.r_w};
            if (expected_q.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               want = expected_q.pop_front();
               for (int i = 0; i < 4; i++)
                  if (got[i] !== want.r[i]) report("r component", got[i], want.r[i]);
               if (rsp.degenerate !== want.degenerate)
                  report("degenerate", rsp.degenerate, want.degenerate);
            end
            rsp_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      comp_type   qa [4], qb [4];
      weight_type w;
      int mode;
      req.valid = 1'b0;
      req.a_x = '0; req.a_y = '0; req.a_z = '0; req.a_w = '0;
      req.b_x = '0; req.b_y = '0; req.b_z = '0; req.b_w = '0;
      req.weight = '0;
      rsp.ready = 1'b0;
      // directed: extremes, zero weight, full weight, over-one weight, flips, degenerate
      qa = '{16'sh4000, 0, 0, 0};           qb = '{0, 16'sh4000, 0, 0};
      push_item(qa, qb, 16'd0);
      push_item(qa, qb, 16'd32768);
      push_item(qa, qb, 16'd65535);
      push_item(qa, qb, 16'd16384);
      qb = '{16'shC000, 0, 0, 0};           // negative dot, flip
      push_item(qa, qb, 16'd8192);
      push_item(qa, qb, 16'd16384);         // flip makes it agree with qa, no cancelling
      qa = '{0, 0, 0, 0};                   qb = '{0, 0, 0, 0};
      push_item(qa, qb, 16'd12345);
      qa = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      qb = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      push_item(qa, qb, 16'd0);
      push_item(qa, qb, 16'd32768);
      push_item(qa, qb, 16'd20000);
      push_item(qb, qb, 16'd65535);
      qa = '{1, 0, 0, 0};                   qb = '{0, 0, 0, 1};
      push_item(qa, qb, 16'd0);
      push_item(qa, qb, 16'd1);
      qa = '{16'sh4000, 0, 0, 0};           qb = '{0, 16'sh4000, 0, 0};
      push_item(qa, qb, 16'd32767);         // zero dot, no flip
      qa = '{16'sh8000, 16'sh7FFF, 1, -1};  qb = '{-1, 1, 16'sh7FFF, 16'sh8000};
      push_item(qa, qb, 16'd16384);
      for (int n = 0; n < N_RANDOM; n++) begin
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 4; i++) begin
            qa[i] = rand_comp(mode);
            qb[i] = ($urandom_range(0, 9) == 0) ? -qa[i] : rand_comp(mode);
         end
         case ($urandom_range(0, 5))
            0:       w = 16'($urandom);
            1:       w = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd32768;
            default: w = 16'($urandom_range(0, 32768));
         endcase
         push_item(qa, qb, w);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req.valid);
      wait (expected_q.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
